// File: rtl/matrix_tile_transpose_core_defines.svh
// Assertion macros for the matrix tile transpose core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef MATRIX_TILE_TRANSPOSE_CORE_DEFINES_SVH
`define MATRIX_TILE_TRANSPOSE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define MTT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define MTT_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MTT_ASSERT(name, clk, rst_n, prop)
`define MTT_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// File: rtl/mtt_pkg.sv
// Shared types and codes for the matrix tile transpose core.
// No dependencies; used by mtt_cell, mtt_seq and the top level.
`timescale 1ns / 1ps

package mtt_pkg;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_DIM_W  = 4;
  localparam int unsigned EW_LOG_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_WIDTH = 2'd2;

  localparam logic [EW_LOG_W-1:0] EW_8  = 2'd0;
  localparam logic [EW_LOG_W-1:0] EW_16 = 2'd1;
  localparam logic [EW_LOG_W-1:0] EW_32 = 2'd2;
  localparam logic [EW_LOG_W-1:0] EW_64 = 2'd3;

  localparam logic [CFG_DIM_W-1:0] TILE_DIM_RST = 4'd8;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } mtt_state_e;

  typedef struct packed {
    logic vld;
    logic wr;
    logic last;
  } lane_ctl_t;

endpackage

// File: rtl/mtt_cell.sv
// One cell of the tile store chain: a row of MAX_DIM entries plus a lane stage.
// Depends on mtt_pkg.
`timescale 1ns / 1ps

module mtt_cell #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned ELEM_BITS = 64,
  parameter int unsigned CELL_ID   = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  mtt_pkg::lane_ctl_t         ctl_i,
  input  logic [$clog2(MAX_DIM)-1:0] cell_i,
  input  logic [$clog2(MAX_DIM)-1:0] slot_i,
  input  logic [ELEM_BITS-1:0]       data_i,
  output mtt_pkg::lane_ctl_t         ctl_o,
  output logic [$clog2(MAX_DIM)-1:0] cell_o,
  output logic [$clog2(MAX_DIM)-1:0] slot_o,
  output logic [ELEM_BITS-1:0]       data_o
);

  localparam int unsigned AW = $clog2(MAX_DIM);

  logic [ELEM_BITS-1:0] row_q [MAX_DIM];
  mtt_pkg::lane_ctl_t   ctl_q;
  logic [AW-1:0]        cell_q;
  logic [AW-1:0]        slot_q;
  logic [ELEM_BITS-1:0] data_q;
  logic                 hit;

  assign hit = ctl_i.vld && (cell_i == AW'(CELL_ID));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= cell_i;
      slot_q <= slot_i;
      if (hit && !ctl_i.wr) begin
        data_q <= row_q[slot_i];
      end else begin
        data_q <= data_i;
      end
      if (hit && ctl_i.wr) begin
        row_q[slot_i] <= data_i;
      end
    end
  end

  assign ctl_o  = ctl_q;
  assign cell_o = cell_q;
  assign slot_o = slot_q;
  assign data_o = data_q;

endmodule

// File: rtl/mtt_seq.sv
// Sequencer: configuration registers, load counter and transposed read order.
// Depends on mtt_pkg; feeds the head of the mtt_cell chain.
`timescale 1ns / 1ps

module mtt_seq #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned ELEM_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             adv_i,
  input  logic                             s_valid_i,
  input  logic [mtt_pkg::WORD_W-1:0]       s_data_i,
  output logic                             s_ready_o,
  output mtt_pkg::lane_ctl_t               iss_ctl_o,
  output logic [$clog2(MAX_DIM)-1:0]       iss_cell_o,
  output logic [$clog2(MAX_DIM)-1:0]       iss_slot_o,
  output logic [ELEM_BITS-1:0]             iss_data_o
);

  localparam int unsigned AW    = $clog2(MAX_DIM);
  localparam int unsigned SW    = AW + 1;
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIM * MAX_DIM + 1);

  logic [mtt_pkg::CFG_DIM_W-1:0] cols_q, rows_q;
  logic [mtt_pkg::EW_LOG_W-1:0]  ew_q;

  mtt_pkg::mtt_state_e state_q, state_d;
  logic [CNT_W-1:0] load_q, load_d, load_inc;
  logic [AW-1:0]    ld_cell_q, ld_cell_d, ld_slot_q, ld_slot_d;
  logic [AW-1:0]    x_q, x_d, y_q, y_d;
  logic [AW-1:0]    rd_cell_q, rd_cell_d, rd_slot_q, rd_slot_d;

  logic [DIM_W-1:0]           cols, rows;
  logic [CNT_W-1:0]           total;
  logic [SW-1:0]              slot_sum;
  logic                       x_last, y_last, accept;
  logic [mtt_pkg::WORD_W-1:0] masked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= mtt_pkg::TILE_DIM_RST;
      rows_q <= mtt_pkg::TILE_DIM_RST;
      ew_q   <= mtt_pkg::EW_64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtt_pkg::CFG_TILE_COLS:  cols_q <= cfg_wdata_i;
        mtt_pkg::CFG_TILE_ROWS:  rows_q <= cfg_wdata_i;
        mtt_pkg::CFG_ELEM_WIDTH: ew_q   <= cfg_wdata_i[mtt_pkg::EW_LOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_q == '0) begin
      cols = DIM_W'(1);
    end else if (cols_q > mtt_pkg::CFG_DIM_W'(MAX_DIM)) begin
      cols = DIM_W'(MAX_DIM);
    end else begin
      cols = DIM_W'(cols_q);
    end
    if (rows_q == '0) begin
      rows = DIM_W'(1);
    end else if (rows_q > mtt_pkg::CFG_DIM_W'(MAX_DIM)) begin
      rows = DIM_W'(MAX_DIM);
    end else begin
      rows = DIM_W'(rows_q);
    end
  end

  assign total = CNT_W'(cols) * CNT_W'(rows);

  always_comb begin
    case (ew_q)
      mtt_pkg::EW_8:  masked = {56'd0, s_data_i[7:0]};
      mtt_pkg::EW_16: masked = {48'd0, s_data_i[15:0]};
      mtt_pkg::EW_32: masked = {32'd0, s_data_i[31:0]};
      default:        masked = s_data_i;
    endcase
  end

  assign s_ready_o = (state_q == mtt_pkg::ST_LOAD) && adv_i;
  assign accept    = s_valid_i && s_ready_o;
  assign load_inc  = load_q + CNT_W'(1);
  assign x_last    = (DIM_W'(x_q) + DIM_W'(1)) == cols;
  assign y_last    = (DIM_W'(y_q) + DIM_W'(1)) == rows;
  assign slot_sum  = SW'(rd_slot_q) + SW'(cols);

  always_comb begin
    state_d   = state_q;
    load_d    = load_q;
    ld_cell_d = ld_cell_q;
    ld_slot_d = ld_slot_q;
    x_d       = x_q;
    y_d       = y_q;
    rd_cell_d = rd_cell_q;
    rd_slot_d = rd_slot_q;

    iss_ctl_o  = '0;
    iss_cell_o = ld_cell_q;
    iss_slot_o = ld_slot_q;
    iss_data_o = ELEM_BITS'(masked);

    case (state_q)
      mtt_pkg::ST_LOAD: begin
        iss_ctl_o.vld = s_valid_i;
        iss_ctl_o.wr  = 1'b1;
        if (accept) begin
          if (load_inc >= total) begin
            state_d   = mtt_pkg::ST_DRAIN;
            load_d    = '0;
            ld_cell_d = '0;
            ld_slot_d = '0;
            x_d       = '0;
            y_d       = '0;
            rd_cell_d = '0;
            rd_slot_d = '0;
          end else begin
            load_d = load_inc;
            if (ld_slot_q == AW'(MAX_DIM - 1)) begin
              ld_slot_d = '0;
              ld_cell_d = ld_cell_q + AW'(1);
            end else begin
              ld_slot_d = ld_slot_q + AW'(1);
            end
          end
        end
      end
      mtt_pkg::ST_DRAIN: begin
        iss_ctl_o.vld  = 1'b1;
        iss_ctl_o.wr   = 1'b0;
        iss_ctl_o.last = x_last && y_last;
        iss_cell_o     = rd_cell_q;
        iss_slot_o     = rd_slot_q;
        if (adv_i) begin
          if (y_last) begin
            y_d       = '0;
            x_d       = x_q + AW'(1);
            rd_cell_d = '0;
            rd_slot_d = x_q + AW'(1);
            if (x_last) begin
              state_d = mtt_pkg::ST_LOAD;
            end
          end else begin
            y_d = y_q + AW'(1);
            if (slot_sum >= SW'(MAX_DIM)) begin
              rd_slot_d = AW'(slot_sum - SW'(MAX_DIM));
              rd_cell_d = rd_cell_q + AW'(1);
            end else begin
              rd_slot_d = AW'(slot_sum);
            end
          end
        end
      end
      default: begin
        state_d = mtt_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mtt_pkg::ST_LOAD;
      load_q    <= '0;
      ld_cell_q <= '0;
      ld_slot_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      rd_cell_q <= '0;
      rd_slot_q <= '0;
    end else begin
      state_q   <= state_d;
      load_q    <= load_d;
      ld_cell_q <= ld_cell_d;
      ld_slot_q <= ld_slot_d;
      x_q       <= x_d;
      y_q       <= y_d;
      rd_cell_q <= rd_cell_d;
      rd_slot_q <= rd_slot_d;
    end
  end

endmodule

// File: rtl/matrix_tile_transpose_core.sv
// Top level of the matrix tile transpose core: sequencer plus a chain of store cells.
// Depends on mtt_pkg, mtt_seq, mtt_cell and matrix_tile_transpose_core_defines.svh.
`timescale 1ns / 1ps
`include "matrix_tile_transpose_core_defines.svh"

// Corner turn for a dense tile of up to MAX_DIM x MAX_DIM elements. Input words
// arrive row-major, one per cycle while the core is loading and the result side
// is not stalled; each is cut to the configured element width and written
// into a chain of MAX_DIM cells, cell c holding linear entries c*MAX_DIM ..
// c*MAX_DIM+MAX_DIM-1. The word that completes the tile starts a burst of
// rows*cols read requests in transposed order, one per cycle while the result
// side is not stalled; input is held off for the whole burst. Every request
// walks the whole chain, cell by cell. The last result carries tlast.
// A stall on the result side freezes the whole chain, input included.

module matrix_tile_transpose_core #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned ELEM_BITS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mtt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mtt_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [mtt_pkg::WORD_W-1:0]     s_axis_tdata,   // [63:0] elem_value
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mtt_pkg::WORD_W-1:0]     m_axis_tdata,   // [63:0] out_value
  output logic                           m_axis_tlast
);

  localparam int unsigned AW = $clog2(MAX_DIM);

  mtt_pkg::lane_ctl_t   ctl_w  [MAX_DIM+1];
  logic [AW-1:0]        cell_w [MAX_DIM+1];
  logic [AW-1:0]        slot_w [MAX_DIM+1];
  logic [ELEM_BITS-1:0] data_w [MAX_DIM+1];
  logic                 adv;

  assign m_axis_tvalid = ctl_w[MAX_DIM].vld && !ctl_w[MAX_DIM].wr;
  assign m_axis_tlast  = ctl_w[MAX_DIM].last;
  assign m_axis_tdata  = mtt_pkg::WORD_W'(data_w[MAX_DIM]);
  assign adv           = !m_axis_tvalid || m_axis_tready;

  mtt_seq #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .iss_ctl_o   (ctl_w[0]),
    .iss_cell_o  (cell_w[0]),
    .iss_slot_o  (slot_w[0]),
    .iss_data_o  (data_w[0])
  );

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    mtt_cell #(
      .MAX_DIM   (MAX_DIM),
      .ELEM_BITS (ELEM_BITS),
      .CELL_ID   (c)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl_w[c]),
      .cell_i (cell_w[c]),
      .slot_i (slot_w[c]),
      .data_i (data_w[c]),
      .ctl_o  (ctl_w[c+1]),
      .cell_o (cell_w[c+1]),
      .slot_o (slot_w[c+1]),
      .data_o (data_w[c+1])
    );
  end

  `MTT_ASSERT(a_stall_blocks_input, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
  `MTT_ASSERT_NEVER(a_no_input_in_burst, clk_i, rst_ni, ctl_w[0].vld && !ctl_w[0].wr && s_axis_tready)
  `MTT_ASSERT(a_last_is_read, clk_i, rst_ni, ctl_w[MAX_DIM].vld && ctl_w[MAX_DIM].last |-> m_axis_tvalid)

endmodule

// File: verif/tb_matrix_tile_transpose_core.sv
// Self-checking bench for matrix_tile_transpose_core: directed and random tiles
// under varied source/sink gaps, checked against a transposed-burst scoreboard.
// Depends on mtt_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_matrix_tile_transpose_core;

  localparam int unsigned MAX_DIM       = 8;
  localparam int unsigned ELEM_BITS     = 64;
  localparam int unsigned STORE_DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned FILL_WRAP     = 128;
  localparam logic [mtt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 4 * MAX_DIM;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TOTAL_ITEMS   = 120;
  localparam longint unsigned CYCLE_LIMIT = 500000;

  typedef enum int { FREE_RUN, SRC_GAPS, SINK_STALLS, BOTH_GAPS } idle_mode_e;

  class corner_turn_sb;
    typedef struct {
      logic [mtt_pkg::WORD_W-1:0] value;
      logic                       last;
    } tword_t;

    logic [mtt_pkg::CFG_DIM_W-1:0] cols_q;
    logic [mtt_pkg::CFG_DIM_W-1:0] rows_q;
    logic [mtt_pkg::EW_LOG_W-1:0]  ew_q;
    logic [mtt_pkg::WORD_W-1:0]    tile_mem [STORE_DEPTH];
    int unsigned                   fill;
    tword_t                        due_q[$];
    int unsigned                   mismatches;

    function new();
      cols_q     = mtt_pkg::TILE_DIM_RST;
      rows_q     = mtt_pkg::TILE_DIM_RST;
      ew_q       = mtt_pkg::EW_64;
      fill       = 0;
      mismatches = 0;
      foreach (tile_mem[i]) tile_mem[i] = '0;
    endfunction

    function void set_reg(logic [mtt_pkg::CFG_IDX_W-1:0]  idx,
                          logic [mtt_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mtt_pkg::CFG_TILE_COLS:  cols_q = data;
        mtt_pkg::CFG_TILE_ROWS:  rows_q = data;
        mtt_pkg::CFG_ELEM_WIDTH: ew_q   = data[mtt_pkg::EW_LOG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned side(logic [mtt_pkg::CFG_DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
    endfunction

    function logic [mtt_pkg::WORD_W-1:0] cut(logic [mtt_pkg::WORD_W-1:0] v);
      int unsigned bits;
      case (ew_q)
        mtt_pkg::EW_8:  bits = 8;
        mtt_pkg::EW_16: bits = 16;
        mtt_pkg::EW_32: bits = 32;
        default:        bits = 64;
      endcase
      if (bits > ELEM_BITS) bits = ELEM_BITS;
      if (bits >= mtt_pkg::WORD_W) return v;
      return v & ((64'd1 << bits) - 64'd1);
    endfunction

    function void load_element(logic [mtt_pkg::WORD_W-1:0] v);
      int unsigned cols;
      int unsigned rows;
      int unsigned total;
      tword_t      w;
      cols  = side(cols_q);
      rows  = side(rows_q);
      total = cols * rows;
      tile_mem[fill % STORE_DEPTH] = cut(v);
      fill = (fill + 1) % FILL_WRAP;
      if (fill < total) return;
      for (int unsigned x = 0; x < cols; x++) begin
        for (int unsigned y = 0; y < rows; y++) begin
          w.value = tile_mem[(y * cols + x) % STORE_DEPTH];
          w.last  = (x * rows + y == total - 1);
          due_q.push_back(w);
        end
      end
      fill = 0;
    endfunction

    function void check_word(logic [mtt_pkg::WORD_W-1:0] value, logic last);
      tword_t w;
      if (due_q.size() == 0) begin
        mismatches++;
        $error("out_value: no word expected, got %h (out_last %b)", value, last);
        return;
      end
      w = due_q.pop_front();
      if (value !== w.value) begin
        mismatches++;
        $error("out_value: expected %h, got %h", w.value, value);
      end
      if (last !== w.last) begin
        mismatches++;
        $error("out_last: expected %b, got %b", w.last, last);
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [mtt_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [mtt_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [mtt_pkg::WORD_W-1:0]     s_axis_tdata;   // [63:0] elem_value
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [mtt_pkg::WORD_W-1:0]     m_axis_tdata;   // [63:0] out_value
  logic                           m_axis_tlast;

  corner_turn_sb   sb = new();
  int unsigned     src_idle_pct;
  int unsigned     sink_stall_pct;
  int unsigned     hold_left;
  int unsigned     items_sent;
  longint unsigned cycles;

  matrix_tile_transpose_core #(
    .MAX_DIM  (MAX_DIM),
    .ELEM_BITS(ELEM_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.load_element(s_axis_tdata);
    end
  end

  function automatic logic [mtt_pkg::WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [mtt_pkg::CFG_DIM_W-1:0] pick_dim();
    int unsigned                   r;
    logic [mtt_pkg::CFG_DIM_W-1:0] d;
    r = $urandom_range(0, 19);
    if (r == 0) d = '0;
    else if (r == 1) d = mtt_pkg::CFG_DIM_W'($urandom_range(MAX_DIM + 1, 15));
    else if (r < 4) d = mtt_pkg::CFG_DIM_W'(MAX_DIM);
    else d = mtt_pkg::CFG_DIM_W'($urandom_range(1, 4));
    return d;
  endfunction

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      FREE_RUN:    begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      SRC_GAPS:    begin src_idle_pct = 86; sink_stall_pct = 0;  end
      SINK_STALLS: begin src_idle_pct = 0;  sink_stall_pct = 86; end
      BOTH_GAPS:   begin src_idle_pct = 8;  sink_stall_pct = 8;  end
      default:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_elem(input logic [mtt_pkg::WORD_W-1:0] v);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(0, 99) < src_idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_words(input int unsigned n);
    repeat (n) send_elem(rand_word());
  endtask

  task automatic cfg_write(input logic [mtt_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [mtt_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup_tile(input logic [mtt_pkg::CFG_DIM_W-1:0] cols,
                            input logic [mtt_pkg::CFG_DIM_W-1:0] rows,
                            input logic [mtt_pkg::EW_LOG_W-1:0]  ew);
    cfg_write(mtt_pkg::CFG_TILE_COLS, cols);
    cfg_write(mtt_pkg::CFG_TILE_ROWS, rows);
    cfg_write(mtt_pkg::CFG_ELEM_WIDTH, ew);
  endtask

  // drop valid, wait out every pending word, then let the chain empty
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned                   seg;
    int unsigned                   total;
    int unsigned                   n;
    logic [mtt_pkg::CFG_DIM_W-1:0] cols;
    logic [mtt_pkg::CFG_DIM_W-1:0] rows;
    logic [mtt_pkg::EW_LOG_W-1:0]  ew;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_left     = 0;
    items_sent    = 0;
    cycles        = 0;
    set_idle(FREE_RUN);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // partial tile in the reset geometry, then shrink the tile below the fill
    send_elem('0);
    send_elem('1);
    send_elem(64'h8000_0000_0000_0001);
    settle();
    cfg_write(mtt_pkg::CFG_TILE_ROWS, 4'd1);
    cfg_write(mtt_pkg::CFG_TILE_COLS, 4'd2);
    send_elem(64'hAAAA_AAAA_AAAA_AAAA);
    settle();

    setup_tile(4'd0, 4'd0, mtt_pkg::EW_8);
    send_elem(64'hFFFF_FFFF_FFFF_FF5A);
    send_elem(64'h0123_4567_89AB_CDEF);
    settle();

    set_idle(SRC_GAPS);
    setup_tile(4'd3, 4'd2, mtt_pkg::EW_16);
    cfg_write(CFG_SPARE, 4'hF);
    send_elem(64'h5555_5555_5555_5555);
    send_elem(64'hAAAA_AAAA_AAAA_AAAA);
    repeat (4) send_elem(rand_word());
    settle();

    set_idle(SINK_STALLS);
    setup_tile(4'd15, 4'd1, mtt_pkg::EW_32);
    repeat (8) send_elem(rand_word());
    settle();

    set_idle(BOTH_GAPS);
    setup_tile(4'd1, 4'd12, mtt_pkg::EW_64);
    repeat (8) send_elem(rand_word());
    settle();

    // hold the sink off while the source keeps offering, so the core backs up
    set_idle(FREE_RUN);
    setup_tile(4'd4, 4'd4, mtt_pkg::EW_64);
    hold_left = HOLD_CYCLES;
    send_words(48);
    settle();

    seg = 0;
    while (items_sent < TOTAL_ITEMS) begin
      set_idle(idle_mode_e'(seg % 4));
      cols = pick_dim();
      rows = pick_dim();
      ew   = mtt_pkg::EW_LOG_W'($urandom_range(0, 3));
      setup_tile(cols, rows, ew);
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(CFG_SPARE, mtt_pkg::CFG_DATA_W'($urandom_range(0, 15)));
      end
      total = sb.side(cols) * sb.side(rows);
      n     = total * $urandom_range(1, 3);
      if (total > 1 && $urandom_range(0, 3) == 0) n = n + $urandom_range(1, total - 1);
      if (n > TOTAL_ITEMS - items_sent) n = TOTAL_ITEMS - items_sent;
      send_words(n);
      settle();
      seg++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
